/* sv/crs_pkg.sv */
// Package: shared constants, codes and types for the complement rank/select block.
`default_nettype none

package crs_pkg;

    // Table and index geometry
    localparam int TABLE_DEPTH    = 1024;
    localparam int INDEX_WIDTH    = 62;
    localparam int ADDR_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W          = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_W         = 10;
    localparam int OP_W           = 2;

    // Configuration registers
    localparam int INDEX_BITS_W    = 6;
    localparam int MARKED_COUNT_W  = 11;
    localparam int CFG_DATA_W      = 11;
    localparam int CFG_INDEX_W     = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_BITS   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MARKED_COUNT = 1'b1;
    localparam logic [INDEX_BITS_W-1:0] INDEX_BITS_RESET = 6'd10;
    localparam logic [MARKED_COUNT_W-1:0] MARKED_COUNT_RESET = 11'd1;

    // Stream packing
    localparam int IN_FIELDS_W  = SLOT_W + 3 * INDEX_WIDTH;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = INDEX_WIDTH + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Operation codes carried in the input tuser
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_SELECT = 2'd1;
    localparam logic [OP_W-1:0] OP_MEMBER = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Work kinds decided by the front end
    typedef enum logic [2:0] {
        KIND_WRITE,
        KIND_SELECT,
        KIND_MEMBER,
        KIND_RANGE,
        KIND_EMPTY
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [SLOT_W-1:0]      slot;
        logic [INDEX_WIDTH-1:0] operand;   // entry value, rank or query index
        logic [INDEX_WIDTH-1:0] top;       // largest index of the space
    } cmd_t;

endpackage

`default_nettype wire

/* sv/complement_rank_select.sv */
// Top level: rank/select over the complement of a sorted table of marked indices.
//
// Load the table with operation 0, one slot per transaction, then issue select
// (operation 1) or membership (operation 2) transactions. Items are classified
// on entry and queued two deep, so the input keeps accepting while the search
// engine works and a finished result waits in the output register. Throughput
// is set by the single read port of the 1024-entry table and the nested binary
// search: a write, an unused code or an out-of-range rank passes from idle
// straight to the done state; a membership test is a binary search over the m
// marked entries, then a final compare read when the search ends inside the
// table; a select runs index_bits outer steps, each an inner binary search
// over the m marked entries. A result the sink has not taken holds the engine
// in its last state. Write configuration only while no transaction is in
// flight. The table has no reset; read only slots that were written.
`default_nettype none

module complement_rank_select import crs_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // slot[9:0], entry_value[71:10], rank[133:72], query_index[195:134], zero fill
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation[1:0]
    input  wire logic [OP_W-1:0]        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // found_index[61:0], is_member[62], zero fill
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    // status[0]
    output logic      [0:0]             m_axis_tuser
);

    localparam int ENTRY_LSB = SLOT_W;
    localparam int RANK_LSB  = SLOT_W + INDEX_WIDTH;
    localparam int QUERY_LSB = SLOT_W + 2 * INDEX_WIDTH;

    cmd_t                   front_cmd;
    cmd_t                   queue_cmd;
    logic [CNT_W-1:0]       eff_count;
    logic                   queue_valid;
    logic                   queue_ready;
    logic [INDEX_WIDTH-1:0] res_found;
    logic                   res_member;
    logic                   res_status;

    crs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .operation   (s_axis_tuser),
        .slot        (s_axis_tdata[SLOT_W-1:0]),
        .entry_value (s_axis_tdata[ENTRY_LSB +: INDEX_WIDTH]),
        .rank        (s_axis_tdata[RANK_LSB +: INDEX_WIDTH]),
        .query_index (s_axis_tdata[QUERY_LSB +: INDEX_WIDTH]),
        .cmd         (front_cmd),
        .eff_count   (eff_count)
    );

    crs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_cmd   (queue_cmd)
    );

    crs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (queue_valid),
        .cmd_ready  (queue_ready),
        .cmd        (queue_cmd),
        .eff_count  (eff_count),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res_found  (res_found),
        .res_member (res_member),
        .res_status (res_status)
    );

    assign m_axis_tdata = OUT_TDATA_W'({res_member, res_found});
    assign m_axis_tuser = res_status;

    // An out-of-range select reports no index
    a_status_no_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> res_found == '0)
        else $error("out-of-range result carries a nonzero index");

    // A membership hit never comes with a range error or an index
    a_member_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res_member |-> !res_status && res_found == '0)
        else $error("membership result mixed with select fields");

    // The engine only pulls a command while no result is pending in its sequencer
    a_pull_idle: assert property (@(posedge clk) disable iff (!rst_n)
        queue_valid && queue_ready |=> !queue_ready)
        else $error("engine took two commands back to back");

endmodule

`default_nettype wire

/* sv/crs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module crs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sv/crs_front.sv */
// Front end: configuration registers and classification of incoming items.
`default_nettype none

module crs_front import crs_pkg::*; (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic [OP_W-1:0]           operation,
    input  wire logic [SLOT_W-1:0]         slot,
    input  wire logic [INDEX_WIDTH-1:0]    entry_value,
    input  wire logic [INDEX_WIDTH-1:0]    rank,
    input  wire logic [INDEX_WIDTH-1:0]    query_index,
    output cmd_t                           cmd,
    output logic      [CNT_W-1:0]          eff_count
);

    logic [INDEX_BITS_W-1:0]   index_bits_reg;
    logic [INDEX_BITS_W-1:0]   index_bits_next;
    logic [MARKED_COUNT_W-1:0] marked_count_reg;
    logic [MARKED_COUNT_W-1:0] marked_count_next;

    logic [INDEX_BITS_W-1:0]   eff_bits;
    logic [INDEX_WIDTH:0]      space;
    logic [INDEX_WIDTH:0]      count_ext;
    logic [INDEX_WIDTH:0]      space_minus;
    logic                      range_err;

    always_comb
    begin
        index_bits_next   = index_bits_reg;
        marked_count_next = marked_count_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INDEX_BITS:   index_bits_next   = cfg_wdata[INDEX_BITS_W-1:0];
                REG_MARKED_COUNT: marked_count_next = cfg_wdata[MARKED_COUNT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg   <= INDEX_BITS_RESET;
            marked_count_reg <= MARKED_COUNT_RESET;
        end
        else
        begin
            index_bits_reg   <= index_bits_next;
            marked_count_reg <= marked_count_next;
        end
    end

    // Saturate the space size and the entry count into their legal ranges
    always_comb
    begin
        priority if (index_bits_reg == '0)
            eff_bits = INDEX_BITS_W'(1);
        else if (index_bits_reg > INDEX_BITS_W'(INDEX_WIDTH))
            eff_bits = INDEX_BITS_W'(INDEX_WIDTH);
        else
            eff_bits = index_bits_reg;

        if (marked_count_reg > MARKED_COUNT_W'(TABLE_DEPTH))
            eff_count = CNT_W'(TABLE_DEPTH);
        else
            eff_count = CNT_W'(marked_count_reg);
    end

    assign space       = (INDEX_WIDTH + 1)'(1) << eff_bits;
    assign count_ext   = (INDEX_WIDTH + 1)'(eff_count);
    assign space_minus = space - count_ext;
    assign range_err   = (count_ext >= space) || ({1'b0, rank} >= space_minus);

    always_comb
    begin
        cmd.slot = slot;
        cmd.top  = INDEX_WIDTH'(space - (INDEX_WIDTH + 1)'(1));
        unique case (operation)
            OP_WRITE:
            begin
                cmd.kind    = KIND_WRITE;
                cmd.operand = entry_value;
            end
            OP_SELECT:
            begin
                cmd.kind    = range_err ? KIND_RANGE : KIND_SELECT;
                cmd.operand = rank;
            end
            OP_MEMBER:
            begin
                cmd.kind    = KIND_MEMBER;
                cmd.operand = query_index;
            end
            OP_NONE:
            begin
                cmd.kind    = KIND_EMPTY;
                cmd.operand = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/crs_queue.sv */
// Short command queue between the front end and the search engine.
`default_nettype none

module crs_queue import crs_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cmd_t in_cmd,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      out_cmd
);

    cmd_t              entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entries[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

/* sv/crs_back.sv */
// Back end: table memory, nested binary-search sequencer and result register.
`default_nettype none

module crs_back import crs_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    output logic                        cmd_ready,
    input  wire cmd_t                   cmd,
    input  wire logic [CNT_W-1:0]       eff_count,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output logic      [INDEX_WIDTH-1:0] res_found,
    output logic                        res_member,
    output logic                        res_status
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] S_OUTER = 4'd1;
    localparam logic [ST_W-1:0] S_IADDR = 4'd2;
    localparam logic [ST_W-1:0] S_ICMP  = 4'd3;
    localparam logic [ST_W-1:0] S_OUPD  = 4'd4;
    localparam logic [ST_W-1:0] S_MADDR = 4'd5;
    localparam logic [ST_W-1:0] S_MCMP  = 4'd6;
    localparam logic [ST_W-1:0] S_MLAST = 4'd7;
    localparam logic [ST_W-1:0] S_DONE  = 4'd8;

    logic [ST_W-1:0]        state_reg,      state_next;
    logic [INDEX_WIDTH-1:0] low_reg,        low_next;
    logic [INDEX_WIDTH-1:0] high_reg,       high_next;
    logic [INDEX_WIDTH-1:0] operand_reg,    operand_next;
    logic [INDEX_WIDTH-1:0] mid_reg,        mid_next;
    logic [CNT_W-1:0]       lo_reg,         lo_next;
    logic [CNT_W-1:0]       hi_reg,         hi_next;
    logic [ADDR_W-1:0]      imid_reg,       imid_next;
    logic                   member_reg,     member_next;
    logic                   status_reg,     status_next;
    logic                   out_valid_reg,  out_valid_next;
    logic [INDEX_WIDTH-1:0] out_found_reg,  out_found_next;
    logic                   out_member_reg, out_member_next;
    logic                   out_status_reg, out_status_next;

    logic                   pop;
    logic                   ram_we;
    logic [ADDR_W-1:0]      raddr;
    logic [INDEX_WIDTH-1:0] rdata;
    logic [CNT_W:0]         inner_sum;
    logic [ADDR_W-1:0]      imid_c;
    logic [INDEX_WIDTH:0]   outer_sum;
    logic [INDEX_WIDTH:0]   mid_plus;
    logic [INDEX_WIDTH:0]   ub_ext;
    logic [INDEX_WIDTH:0]   unmarked;
    logic                   inner_open;

    assign cmd_ready  = (state_reg == S_IDLE);
    assign pop        = cmd_valid && cmd_ready;
    assign ram_we     = pop && (cmd.kind == KIND_WRITE);

    assign inner_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign imid_c     = inner_sum[ADDR_W:1];
    assign inner_open = (lo_reg < hi_reg);
    assign outer_sum  = {1'b0, low_reg} + {1'b0, high_reg};
    assign mid_plus   = {1'b0, mid_reg} + (INDEX_WIDTH + 1)'(1);
    assign ub_ext     = (INDEX_WIDTH + 1)'(lo_reg);
    // Clamp a negative unmarked count to zero
    assign unmarked   = (mid_plus >= ub_ext) ? (mid_plus - ub_ext) : '0;

    // Final membership read goes to the settled lower bound
    assign raddr = (state_reg == S_MADDR && !inner_open) ? lo_reg[ADDR_W-1:0] : imid_c;

    crs_ram #(
        .WIDTH (INDEX_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd.slot[ADDR_W-1:0]),
        .wdata (cmd.operand),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        operand_next    = operand_reg;
        mid_next        = mid_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        imid_next       = imid_reg;
        member_next     = member_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_member_next = out_member_reg;
        out_status_next = out_status_reg;

        // Drop the result once the sink takes it
        if (out_valid_reg && res_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    low_next     = '0;
                    high_next    = cmd.top;
                    operand_next = cmd.operand;
                    lo_next      = '0;
                    hi_next      = eff_count;
                    member_next  = 1'b0;
                    status_next  = (cmd.kind == KIND_RANGE);
                    unique case (cmd.kind)
                        KIND_SELECT: state_next = S_OUTER;
                        KIND_MEMBER: state_next = S_MADDR;
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_OUTER:
            begin
                if (low_reg < high_reg)
                begin
                    mid_next   = outer_sum[INDEX_WIDTH:1];
                    lo_next    = '0;
                    hi_next    = eff_count;
                    state_next = S_IADDR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_IADDR:
            begin
                if (inner_open)
                begin
                    imid_next  = imid_c;
                    state_next = S_ICMP;
                end
                else
                begin
                    state_next = S_OUPD;
                end
            end
            S_ICMP:
            begin
                if (rdata <= mid_reg)
                    lo_next = CNT_W'(imid_reg) + CNT_W'(1);
                else
                    hi_next = CNT_W'(imid_reg);
                state_next = S_IADDR;
            end
            S_OUPD:
            begin
                if (unmarked > {1'b0, operand_reg})
                    high_next = mid_reg;
                else
                    low_next  = mid_plus[INDEX_WIDTH-1:0];
                state_next = S_OUTER;
            end
            S_MADDR:
            begin
                priority if (inner_open)
                begin
                    imid_next  = imid_c;
                    state_next = S_MCMP;
                end
                else if (lo_reg < eff_count)
                begin
                    state_next = S_MLAST;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MCMP:
            begin
                if (rdata < operand_reg)
                    lo_next = CNT_W'(imid_reg) + CNT_W'(1);
                else
                    hi_next = CNT_W'(imid_reg);
                state_next = S_MADDR;
            end
            S_MLAST:
            begin
                member_next = (rdata == operand_reg);
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = low_reg;
                    out_member_next = member_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg        <= low_next;
        high_reg       <= high_next;
        operand_reg    <= operand_next;
        mid_reg        <= mid_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        imid_reg       <= imid_next;
        member_reg     <= member_next;
        status_reg     <= status_next;
        out_found_reg  <= out_found_next;
        out_member_reg <= out_member_next;
        out_status_reg <= out_status_next;
    end

    assign res_valid  = out_valid_reg;
    assign res_found  = out_found_reg;
    assign res_member = out_member_reg;
    assign res_status = out_status_reg;

endmodule

`default_nettype wire

/* tb/complement_rank_select_tb.sv */
// Testbench: self-checking stream test of the complement rank/select block.
module complement_rank_select_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crs_pkg::*;

    localparam int TOTAL_ITEMS   = 1250;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 40;
    // about 1300 transactions, each at worst a full-table select at 62 bits
    // plus stall bursts, taken about seven times over
    localparam int LIMIT_CYCLES  = 15_000_000;

    typedef logic [INDEX_WIDTH-1:0] index_t;
    localparam index_t ALL_ONES = '1;

    typedef struct packed {
        index_t found;
        logic   member;
        logic   status;
    } answer_t;

    class crs_scoreboard;
        index_t                  marks [TABLE_DEPTH];
        logic [INDEX_BITS_W-1:0] bits_reg;
        logic [MARKED_COUNT_W-1:0] count_reg;
        answer_t                 expected_answers [$];
        int                      errors;

        function new();
            bits_reg  = INDEX_BITS_RESET;
            count_reg = MARKED_COUNT_RESET;
            errors    = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_INDEX_BITS)
                bits_reg = data[INDEX_BITS_W-1:0];
            else
                count_reg = data[MARKED_COUNT_W-1:0];
        endfunction

        // entries among the first m that are at or below x
        function longint unsigned ranked_at_or_below(longint unsigned x, longint unsigned m);
            longint unsigned lo, hi, mid;
            lo = 0;
            hi = m;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (marks[mid] <= x)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return lo;
        endfunction

        function logic holds(longint unsigned x, longint unsigned m);
            longint unsigned lo, hi, mid;
            lo = 0;
            hi = m;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (marks[mid] < x)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return (lo < m && marks[lo] == x);
        endfunction

        function answer_t predict_answer(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                         index_t value, index_t rank, index_t query);
            answer_t a;
            longint unsigned m, width, space, low, high, mid, seen, unmarked_upto;
            a = '0;
            m = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
            width = bits_reg;
            if (width < 1)
                width = 1;
            if (width > INDEX_WIDTH)
                width = INDEX_WIDTH;
            case (op)
                OP_WRITE: marks[slot] = value;
                OP_SELECT:
                begin
                    space = 64'd1 << width;
                    if (m >= space || rank >= space - m)
                        a.status = 1'b1;
                    else
                    begin
                        low  = 0;
                        high = space - 1;
                        while (low < high)
                        begin
                            mid = low + (high - low) / 2;
                            seen = ranked_at_or_below(mid, m);
                            // clamp at zero when the table is not well formed
                            unmarked_upto = (mid + 1 >= seen) ? mid + 1 - seen : 0;
                            if (unmarked_upto > rank)
                                high = mid;
                            else
                                low = mid + 1;
                        end
                        a.found = index_t'(low);
                    end
                end
                OP_MEMBER: a.member = holds(query, m);
                default: ;
            endcase
            return a;
        endfunction

        function void note_accepted(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                    index_t value, index_t rank, index_t query);
            expected_answers.push_back(predict_answer(op, slot, value, rank, query));
        endfunction

        function void check_answer(answer_t got);
            answer_t want;
            if (expected_answers.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_answers.pop_front();
            if (got.found !== want.found)
            begin
                $display("%0t ns: found_index mismatch, expected %h actual %h",
                         $time, want.found, got.found);
                errors++;
            end
            if (got.member !== want.member)
            begin
                $display("%0t ns: is_member mismatch, expected %b actual %b",
                         $time, want.member, got.member);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t ns: status mismatch, expected %b actual %b",
                         $time, want.status, got.status);
                errors++;
            end
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [OP_W-1:0]        s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    crs_scoreboard sb;
    bit            calm = 1'b0;
    bit            hold_req = 1'b0;
    int            items_sent = 0;
    int            cycles = 0;

    complement_rank_select DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic index_t rand62();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[INDEX_WIDTH-1:0];
    endfunction

    function automatic longint unsigned rand_below(longint unsigned n);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r % n;
    endfunction

    function automatic int pick_bits();
        int c;
        c = $urandom_range(0, 19);
        if (c < 12)
            return $urandom_range(1, 12);
        if (c < 17)
            return $urandom_range(13, 40);
        return $urandom_range(41, INDEX_WIDTH);
    endfunction

    function automatic index_t pick_rank(int m, longint unsigned space);
        longint unsigned avail;
        if (m >= space)
            return ($urandom_range(0, 1) != 0) ? index_t'(rand_below(4)) : rand62();
        avail = space - m;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return index_t'(avail - 1);
            2: return index_t'(avail);
            3: return rand62();
            4: return index_t'(avail + rand_below(8));
            default: return index_t'(rand_below(avail));
        endcase
    endfunction

    function automatic index_t pick_query(int m, longint unsigned space);
        index_t base;
        base = (m > 0) ? sb.marks[$urandom_range(0, m - 1)] : rand62();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return base;
            4: return base + 1'b1;
            5: return base - 1'b1;
            6, 7: return index_t'(rand_below(space));
            8: return rand62();
            default: return ($urandom_range(0, 1) != 0) ? index_t'(space - 1) : '0;
        endcase
    endfunction

    // offer one transaction, hold it until accepted, then log the expectation
    task automatic send_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                             input index_t value, input index_t rank, input index_t query);
        logic [IN_TDATA_W-1:0] word;
        int gap;
        word = '0;
        word[SLOT_W-1:0] = slot;
        word[SLOT_W +: INDEX_WIDTH] = value;
        word[SLOT_W + INDEX_WIDTH +: INDEX_WIDTH] = rank;
        word[SLOT_W + 2 * INDEX_WIDTH +: INDEX_WIDTH] = query;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        sb.note_accepted(op, slot, value, rank, query);
        items_sent++;
    endtask

    task automatic write_entry(input logic [SLOT_W-1:0] slot, input index_t value);
        send_item(OP_WRITE, slot, value, rand62(), rand62());
    endtask

    task automatic select_rank(input index_t rank);
        send_item(OP_SELECT, SLOT_W'($urandom_range(0, TABLE_DEPTH - 1)), rand62(), rank,
                  rand62());
    endtask

    task automatic test_member(input index_t query);
        send_item(OP_MEMBER, SLOT_W'($urandom_range(0, TABLE_DEPTH - 1)), rand62(), rand62(),
                  query);
    endtask

    task automatic send_none();
        send_item(OP_NONE, SLOT_W'($urandom_range(0, TABLE_DEPTH - 1)), rand62(), rand62(),
                  rand62());
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_register(idx, data);
    endtask

    // program the space size and the live count; unused high bits get noise
    task automatic set_space(input int width, input int count_raw);
        logic [CFG_DATA_W-1:0] d;
        int raw;
        raw = width;
        if (width == 1 && $urandom_range(0, 2) == 0)
            raw = 0;
        if (width == INDEX_WIDTH && $urandom_range(0, 2) == 0)
            raw = 63;
        d = CFG_DATA_W'(raw);
        d[CFG_DATA_W-1:INDEX_BITS_W] = (CFG_DATA_W - INDEX_BITS_W)'($urandom_range(0, 31));
        write_register(REG_INDEX_BITS, d);
        write_register(REG_MARKED_COUNT, CFG_DATA_W'(count_raw));
    endtask

    // drop valid and wait until every result is back
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // load slots 0..m-1 with ascending unique values (below space when m fits), or junk if broken
    task automatic load_table(input int m, input longint unsigned space, input bit broken);
        longint unsigned slack, prev, gap, lim, v;
        int mode;
        slack = (m < space) ? space - m : 0;
        mode  = $urandom_range(0, 3);
        prev  = 0;
        v     = 0;
        gap   = 0;
        for (int i = 0; i < m; i++)
        begin
            if (broken)
                v = (space > 1 && $urandom_range(0, 1) != 0) ? rand_below(space) : rand62();
            else if (m >= space)
                v = i;
            else
            begin
                if (mode == 0)
                    gap = 0;
                else if (mode == 1)
                    gap = (i == 0) ? slack : 0;
                else
                begin
                    lim = slack * 2 / (m - i);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : rand_below(lim + 1);
                    if (gap > slack)
                        gap = slack;
                end
                slack -= gap;
                v = (i == 0) ? gap : prev + 1 + gap;
                prev = v;
            end
            if ($urandom_range(0, 31) == 0)
                send_none();
            write_entry(SLOT_W'(i), index_t'(v));
        end
    endtask

    task automatic run_queries(input int m, input longint unsigned space, input int n);
        int c;
        for (int i = 0; i < n; i++)
        begin
            c = $urandom_range(0, 99);
            if (c < 48)
                select_rank(pick_rank(m, space));
            else if (c < 88)
                test_member(pick_query(m, space));
            else if (c < 94)
                send_none();
            else if (m < TABLE_DEPTH)
                write_entry(SLOT_W'($urandom_range(m, TABLE_DEPTH - 1)), rand62());
            else
                write_entry(SLOT_W'($urandom_range(0, TABLE_DEPTH - 1)), rand62());
        end
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        int burst;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 12);
                m_axis_tready <= 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        answer_t got;
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            got.found  = m_axis_tdata[INDEX_WIDTH-1:0];
            got.member = m_axis_tdata[INDEX_WIDTH];
            got.status = m_axis_tuser[0];
            sb.check_answer(got);
        end
    end

    initial
    begin
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("complement_rank_select_tb: errors");
        $finish;
    end

    initial
    begin
        int width, m, count_raw, c, start_items;
        longint unsigned space;
        bit big;

        sb            = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_NONE;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: 1024-index space, one live entry
        write_entry(SLOT_W'(0), index_t'(5));
        select_rank('0);
        select_rank(index_t'(5));
        select_rank(index_t'(1022));
        select_rank(index_t'(1023));
        select_rank(ALL_ONES);
        test_member(index_t'(5));
        test_member(index_t'(6));
        test_member(ALL_ONES);
        send_item(OP_NONE, '1, ALL_ONES, ALL_ONES, ALL_ONES);
        write_entry(SLOT_W'(TABLE_DEPTH - 1), ALL_ONES);
        write_entry(SLOT_W'(1), index_t'(6));
        drain();

        // index_bits of zero saturates up, empty table
        write_register(REG_INDEX_BITS, 11'h7C0);
        write_register(REG_MARKED_COUNT, 11'd0);
        select_rank('0);
        select_rank(index_t'(1));
        select_rank(index_t'(2));
        test_member('0);
        drain();

        // index_bits of 63 saturates down to the full width
        write_register(REG_INDEX_BITS, 11'h03F);
        write_register(REG_MARKED_COUNT, 11'd2);
        select_rank(ALL_ONES - 2);
        select_rank(ALL_ONES - 1);
        select_rank(index_t'(5));
        test_member(index_t'(6));
        drain();

        // count covers the whole space: every rank out of range
        write_register(REG_INDEX_BITS, 11'd1);
        write_register(REG_MARKED_COUNT, 11'd2);
        select_rank('0);
        test_member(index_t'(1));
        drain();

        // full table, with the receiver holding off while the load streams in
        width = $urandom_range(11, INDEX_WIDTH);
        space = 64'd1 << width;
        set_space(width, 2047);
        hold_req = 1'b1;
        load_table(TABLE_DEPTH, space, 1'b0);
        run_queries(TABLE_DEPTH, space, 24);
        drain();
        set_space(10, TABLE_DEPTH);
        run_queries(TABLE_DEPTH, 64'd1 << 10, 6);
        drain();
        set_space(11, TABLE_DEPTH);
        run_queries(TABLE_DEPTH, 64'd1 << 11, 6);
        drain();

        // random batches fill up the rest of the item budget
        start_items = items_sent;
        while (items_sent < TOTAL_ITEMS)
        begin
            if ((items_sent - start_items) * 4 >= (TOTAL_ITEMS - start_items) * 3)
                calm = 1'b1;
            width = pick_bits();
            space = 64'd1 << width;
            c     = $urandom_range(0, 99);
            big   = 1'b0;
            if (c < 70)
                m = $urandom_range(1, 24);
            else if (c < 85)
                m = $urandom_range(25, 120);
            else if (c < 90)
                m = $urandom_range(121, 300);
            else if (c < 95)
                m = 0;
            else
            begin
                big = 1'b1;
                m   = TABLE_DEPTH;
            end
            // counts at or above the depth reuse the table loaded earlier
            count_raw = big ? $urandom_range(TABLE_DEPTH, 2047) : m;
            set_space(width, count_raw);
            if (!big)
                load_table(m, space, $urandom_range(0, 19) == 0);
            run_queries(m, space, big ? 10 : $urandom_range(8, 36));
            drain();
        end

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("complement_rank_select_tb: clean");
        else
            $display("complement_rank_select_tb: errors");
        $finish;
    end

endmodule

/* sim.f */
sv/crs_pkg.sv
sv/crs_ram.sv
sv/crs_front.sv
sv/crs_queue.sv
sv/crs_back.sv
sv/complement_rank_select.sv
tb/complement_rank_select_tb.sv
